@@ hw/rtl/clns_pkg.sv @@
// Shared types, codes and constants for the character LCD nibble sequencer.
package clns_pkg;

    // Request kinds
    localparam logic [1:0] CMD_DATA   = 2'd0;
    localparam logic [1:0] CMD_INSTR  = 2'd1;
    localparam logic [1:0] CMD_CURSOR = 2'd2;
    localparam logic [1:0] CMD_INIT   = 2'd3;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_WAIT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_UP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_INIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_INIT = 3'd4;

    localparam int unsigned CFG_W  = 16;
    localparam int unsigned WAIT_W = 17;

    localparam logic [CFG_W-1:0] SETTLE_RST     = 16'd50;
    localparam logic [CFG_W-1:0] LONG_WAIT_RST  = 16'd2000;
    localparam logic [CFG_W-1:0] POWER_UP_RST   = 16'd50000;
    localparam logic [CFG_W-1:0] FIRST_INIT_RST = 16'd5000;
    localparam logic [CFG_W-1:0] SHORT_INIT_RST = 16'd150;

    // Instructions that get the long wait
    localparam logic [7:0] INSTR_CLEAR = 8'h01;
    localparam logic [7:0] INSTR_HOME  = 8'h02;

    // Init nibbles and the last steps of each init phase
    localparam logic [3:0] NIB_WAKE    = 4'h3;
    localparam logic [3:0] NIB_4BIT    = 4'h2;
    localparam logic [2:0] LAST_NIB    = 3'd3;
    localparam logic [2:0] LAST_INSTR  = 3'd4;

    // Set DDRAM address instruction
    localparam logic DDRAM_SET = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POWER,
        ST_INIT_NIB,
        ST_HI,
        ST_LO
    } state_t;

    typedef enum logic [1:0] {
        EV_POWER,
        EV_INIT_NIB,
        EV_HI,
        EV_LO
    } event_t;

    typedef struct packed {
        logic       load;       // latch the request
        logic       emit;       // produce one event
        event_t     ev;
        logic       init_byte;  // byte comes from the init instruction list
        logic [2:0] step;
        logic       last;
    } ctrl_t;

    function automatic logic [7:0] init_instr(input logic [2:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd0:    b = 8'h28;
            3'd1:    b = 8'h08;
            3'd2:    b = 8'h01;
            3'd3:    b = 8'h06;
            default: b = 8'h0C;
        endcase
        return b;
    endfunction

endpackage

@@ hw/rtl/clns_ctrl.sv @@
// Sequencing state machine: walks the events of one request.
module clns_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [1:0]     command,
    output logic           busy,
    output clns_pkg::ctrl_t ctl
);
    import clns_pkg::*;

    state_t     state_reg, state_next;
    logic [2:0] step_reg, step_next;
    logic       init_reg, init_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            init_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            init_reg  <= init_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        init_next     = init_reg;
        ctl.load      = 1'b0;
        ctl.emit      = 1'b0;
        ctl.ev        = EV_HI;
        ctl.init_byte = init_reg;
        ctl.step      = step_reg;
        ctl.last      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ctl.load  = 1'b1;
                    step_next = '0;
                    init_next = (command == CMD_INIT);
                    state_next = (command == CMD_INIT) ? ST_POWER : ST_HI;
                end
            end
            ST_POWER:
            begin
                ctl.emit   = 1'b1;
                ctl.ev     = EV_POWER;
                state_next = ST_INIT_NIB;
            end
            ST_INIT_NIB:
            begin
                ctl.emit = 1'b1;
                ctl.ev   = EV_INIT_NIB;
                if (step_reg == LAST_NIB)
                begin
                    step_next  = '0;
                    state_next = ST_HI;
                end
                else
                begin
                    step_next = step_reg + 3'd1;
                end
            end
            ST_HI:
            begin
                ctl.emit   = 1'b1;
                ctl.ev     = EV_HI;
                state_next = ST_LO;
            end
            ST_LO:
            begin
                ctl.emit = 1'b1;
                ctl.ev   = EV_LO;
                ctl.last = !init_reg || (step_reg == LAST_INSTR);
                if (ctl.last)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    step_next  = step_reg + 3'd1;
                    state_next = ST_HI;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

@@ hw/rtl/clns_datapath.sv @@
// Datapath: timing registers, request latch and event output register.
module clns_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  clns_pkg::ctrl_t                   ctl,
    input  logic [1:0]                        command,
    input  logic [7:0]                        value,
    input  logic [5:0]                        col,
    input  logic                              row,
    input  logic                              cfg_write,
    input  logic [clns_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [clns_pkg::CFG_W-1:0]        cfg_data,
    output logic                              strobe,
    output logic                              reg_select,
    output logic [3:0]                        nibble,
    output logic                              pulse,
    output logic [clns_pkg::WAIT_W-1:0]       wait_us,
    output logic                              last
);
    import clns_pkg::*;

    logic [CFG_W-1:0] settle_reg, long_wait_reg, power_up_reg, first_init_reg, short_init_reg;
    logic [7:0]       byte_reg;
    logic             rs_reg;

    logic              strobe_reg;
    logic              rs_out_reg, rs_out_next;
    logic [3:0]        nib_reg, nib_next;
    logic              pulse_reg, pulse_next;
    logic [WAIT_W-1:0] wait_reg, wait_next;
    logic              last_reg;

    logic [7:0]        cur_byte;
    logic              cur_rs;
    logic              long_hit;
    logic [CFG_W-1:0]  extra;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg     <= SETTLE_RST;
            long_wait_reg  <= LONG_WAIT_RST;
            power_up_reg   <= POWER_UP_RST;
            first_init_reg <= FIRST_INIT_RST;
            short_init_reg <= SHORT_INIT_RST;
        end
        else if (cfg_write)
        begin
            // indexes beyond the list are dropped
            unique case (cfg_index)
                CFG_SETTLE:     settle_reg     <= cfg_data;
                CFG_LONG_WAIT:  long_wait_reg  <= cfg_data;
                CFG_POWER_UP:   power_up_reg   <= cfg_data;
                CFG_FIRST_INIT: first_init_reg <= cfg_data;
                CFG_SHORT_INIT: short_init_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Latch the byte to send; set cursor folds row into address bit 6
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            unique case (command)
                CMD_DATA:
                begin
                    byte_reg <= value;
                    rs_reg   <= 1'b1;
                end
                CMD_CURSOR:
                begin
                    byte_reg <= {DDRAM_SET, row, col};
                    rs_reg   <= 1'b0;
                end
                default:
                begin
                    byte_reg <= value;
                    rs_reg   <= 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        cur_byte = ctl.init_byte ? init_instr(ctl.step) : byte_reg;
        cur_rs   = ctl.init_byte ? 1'b0 : rs_reg;
        long_hit = !cur_rs && (cur_byte == INSTR_CLEAR || cur_byte == INSTR_HOME);
        extra    = '0;
        rs_out_next = cur_rs;
        nib_next    = cur_byte[7:4];
        pulse_next  = 1'b1;
        unique case (ctl.ev)
            EV_POWER:
            begin
                rs_out_next = 1'b0;
                nib_next    = '0;
                pulse_next  = 1'b0;
            end
            EV_INIT_NIB:
            begin
                rs_out_next = 1'b0;
                nib_next    = (ctl.step == LAST_NIB) ? NIB_4BIT : NIB_WAKE;
                extra       = (ctl.step == '0) ? first_init_reg : short_init_reg;
            end
            EV_HI:
            begin
                nib_next = cur_byte[7:4];
            end
            EV_LO:
            begin
                nib_next = cur_byte[3:0];
                extra    = long_hit ? long_wait_reg : '0;
            end
            default:
            begin
                nib_next = cur_byte[7:4];
            end
        endcase
        if (ctl.ev == EV_POWER)
        begin
            wait_next = {1'b0, power_up_reg};
        end
        else
        begin
            wait_next = {1'b0, settle_reg} + {1'b0, extra};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= ctl.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            rs_out_reg <= rs_out_next;
            nib_reg    <= nib_next;
            pulse_reg  <= pulse_next;
            wait_reg   <= wait_next;
            last_reg   <= ctl.last;
        end
    end

    assign strobe     = strobe_reg;
    assign reg_select = rs_out_reg;
    assign nibble     = nib_reg;
    assign pulse      = pulse_reg;
    assign wait_us    = wait_reg;
    assign last       = last_reg;

endmodule

@@ hw/rtl/char_lcd_nibble_sequencer.sv @@
// Top level of the character LCD nibble sequencer (4-bit bus events).
//
//  channel   handshake              payload
//  --------  ---------------------  ------------------------------------------
//  request   start / busy           command, value, col, row
//  event     strobe (one cycle)     reg_select, nibble, pulse, wait_us, last
//  config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Byte requests form 2 events and initialize forms 15, one per cycle, through an output
// register: the first event is formed in the state after start is taken, and the
// output register then puts it on the ports. busy drops the cycle after the last event
// is formed; start is taken at the end of that cycle at the earliest.
// Reset loads the default timing values and returns the sequencer to idle.
// Events are never held off: each one is on the ports for one cycle only.
module char_lcd_nibble_sequencer (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      command,
    input  logic [7:0]                      value,
    input  logic [5:0]                      col,
    input  logic                            row,
    output logic                            strobe,
    output logic                            reg_select,
    output logic [3:0]                      nibble,
    output logic                            pulse,
    output logic [clns_pkg::WAIT_W-1:0]     wait_us,
    output logic                            last,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [clns_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [clns_pkg::CFG_W-1:0]      cfg_data
);
    import clns_pkg::*;

    ctrl_t ctl;

    assign cfg_ready = 1'b1;

    clns_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .busy    (busy),
        .ctl     (ctl)
    );

    clns_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .command    (command),
        .value      (value),
        .col        (col),
        .row        (row),
        .cfg_write  (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .strobe     (strobe),
        .reg_select (reg_select),
        .nibble     (nibble),
        .pulse      (pulse),
        .wait_us    (wait_us),
        .last       (last)
    );

endmodule

@@ test/tb_char_lcd_nibble_sequencer.sv @@
// Testbench for the character LCD nibble sequencer: directed and random requests, checked per event.
module tb_char_lcd_nibble_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    import clns_pkg::*;

    localparam int IDLE_PCT     = 18;
    localparam int MAX_GAP      = 16;
    localparam int DRAIN_CYCLES = 6;
    localparam int STALL_LIMIT  = 2000;
    localparam int INIT_LEN     = 5;
    localparam logic [8*INIT_LEN-1:0] INIT_SEQ = {8'h28, 8'h08, 8'h01, 8'h06, 8'h0C};
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX = '1;

    typedef struct packed {
        logic              reg_select;
        logic [3:0]        nibble;
        logic              pulse;
        logic [WAIT_W-1:0] wait_us;
        logic              last;
    } lcd_event_t;

    class lcd_event_scoreboard;
        logic [CFG_W-1:0] settle_us;
        logic [CFG_W-1:0] long_wait_us;
        logic [CFG_W-1:0] power_up_us;
        logic [CFG_W-1:0] first_init_us;
        logic [CFG_W-1:0] short_init_us;
        lcd_event_t       pending_events[$];
        int               errors;

        function new();
            settle_us     = SETTLE_RST;
            long_wait_us  = LONG_WAIT_RST;
            power_up_us   = POWER_UP_RST;
            first_init_us = FIRST_INIT_RST;
            short_init_us = SHORT_INIT_RST;
            errors        = 0;
        endfunction

        function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_SETTLE:     settle_us     = data;
                CFG_LONG_WAIT:  long_wait_us  = data;
                CFG_POWER_UP:   power_up_us   = data;
                CFG_FIRST_INIT: first_init_us = data;
                CFG_SHORT_INIT: short_init_us = data;
                default: ;
            endcase
        endfunction

        function logic [WAIT_W-1:0] add_wait(logic [CFG_W-1:0] a, logic [CFG_W-1:0] b);
            logic [WAIT_W-1:0] s;
            s = {1'b0, a};
            s = s + {1'b0, b};
            return s;
        endfunction

        function void push_event(logic rs, logic [3:0] nib, logic pls,
                                 logic [WAIT_W-1:0] delay, logic is_last);
            lcd_event_t e;
            e.reg_select = rs;
            e.nibble     = nib;
            e.pulse      = pls;
            e.wait_us    = delay;
            e.last       = is_last;
            pending_events.push_back(e);
        endfunction

        // High nibble first; only instruction clear and home get the long wait.
        function void push_byte(logic [7:0] code, logic rs, logic is_last);
            logic [WAIT_W-1:0] lo_wait;
            lo_wait = {1'b0, settle_us};
            if (!rs && (code == INSTR_CLEAR || code == INSTR_HOME))
                lo_wait = add_wait(settle_us, long_wait_us);
            push_event(rs, code[7:4], 1'b1, {1'b0, settle_us}, 1'b0);
            push_event(rs, code[3:0], 1'b1, lo_wait, is_last);
        endfunction

        function void note_request(logic [1:0] cmd, logic [7:0] val, logic [5:0] c, logic r);
            logic [6:0] addr;
            addr = {1'b0, c};
            if (r)
                addr = addr + 7'h40;
            case (cmd)
                CMD_DATA:   push_byte(val, 1'b1, 1'b1);
                CMD_INSTR:  push_byte(val, 1'b0, 1'b1);
                CMD_CURSOR: push_byte({DDRAM_SET, addr}, 1'b0, 1'b1);
                default:
                begin
                    push_event(1'b0, 4'h0, 1'b0, {1'b0, power_up_us}, 1'b0);
                    push_event(1'b0, NIB_WAKE, 1'b1, add_wait(settle_us, first_init_us), 1'b0);
                    push_event(1'b0, NIB_WAKE, 1'b1, add_wait(settle_us, short_init_us), 1'b0);
                    push_event(1'b0, NIB_WAKE, 1'b1, add_wait(settle_us, short_init_us), 1'b0);
                    push_event(1'b0, NIB_4BIT, 1'b1, add_wait(settle_us, short_init_us), 1'b0);
                    for (int i = 0; i < INIT_LEN; i++)
                        push_byte(INIT_SEQ[8*(INIT_LEN-1-i) +: 8], 1'b0, i == INIT_LEN - 1);
                end
            endcase
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_event(lcd_event_t got);
            lcd_event_t want;
            if (pending_events.size() == 0)
            begin
                $display("%0t: unexpected event: expected none, %s=%0h nib=%0h pulse=%0h",
                         $time, "actual rs", got.reg_select, got.nibble, got.pulse,
                         " wait=%0h last=%0h", got.wait_us, got.last);
                errors++;
                return;
            end
            want = pending_events.pop_front();
            compare("reg_select", 32'(want.reg_select), 32'(got.reg_select));
            compare("nibble", 32'(want.nibble), 32'(got.nibble));
            compare("pulse", 32'(want.pulse), 32'(got.pulse));
            compare("wait_us", 32'(want.wait_us), 32'(got.wait_us));
            compare("last", 32'(want.last), 32'(got.last));
        endfunction

        function int pending();
            return pending_events.size();
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [1:0]           command;
    logic [7:0]           value;
    logic [5:0]           col;
    logic                 row;
    logic                 strobe;
    logic                 reg_select;
    logic [3:0]           nibble;
    logic                 pulse;
    logic [WAIT_W-1:0]    wait_us;
    logic                 last;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    lcd_event_scoreboard sb;
    int                  stall_cycles = 0;

    char_lcd_nibble_sequencer u_dut (.*);

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_request(command, value, col, row);
            if (cfg_valid && cfg_ready)
                sb.note_config(cfg_index, cfg_data);
            if (strobe)
                sb.check_event(lcd_event_t'{reg_select, nibble, pulse, wait_us, last});
        end
    end

    // Count cycles in which no beat moves on any channel.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Leave start high on return so the next request can follow without a gap.
    task automatic send_request(logic [1:0] cmd, logic [7:0] val, logic [5:0] c, logic r);
        start   <= 1'b1;
        command <= cmd;
        value   <= val;
        col     <= c;
        row     <= r;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Step past the accepting edge first so busy covers the last request.
    task automatic end_requests();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0 || busy)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic program_timing(logic [CFG_W-1:0] settle, logic [CFG_W-1:0] long_wait,
                                  logic [CFG_W-1:0] power_up, logic [CFG_W-1:0] first_init,
                                  logic [CFG_W-1:0] short_init, bit with_unused);
        write_reg(CFG_SETTLE, settle);
        write_reg(CFG_LONG_WAIT, long_wait);
        write_reg(CFG_POWER_UP, power_up);
        write_reg(CFG_FIRST_INIT, first_init);
        write_reg(CFG_SHORT_INIT, short_init);
        // Indexes past the last register must not disturb any timing value.
        if (with_unused)
            for (int i = CFG_SHORT_INIT + 1; i <= CFG_IDX_MAX; i++)
                write_reg(CFG_IDX_W'(i), CFG_W'($urandom_range(0, 65535)));
        cfg_valid <= 1'b0;
    endtask

    task automatic program_random(int hi);
        program_timing(CFG_W'($urandom_range(0, hi)), CFG_W'($urandom_range(0, hi)),
                       CFG_W'($urandom_range(0, hi)), CFG_W'($urandom_range(0, hi)),
                       CFG_W'($urandom_range(0, hi)), 1'b0);
    endtask

    task automatic run_random_phase(int count, int quiet);
        logic [1:0] cmd;
        logic [7:0] val;
        int         k;
        for (int n = 0; n < count; n++)
        begin
            if (n >= quiet && $urandom_range(0, 99) < IDLE_PCT)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
            end
            k = $urandom_range(0, 99);
            if (k < 35)
                cmd = CMD_DATA;
            else if (k < 65)
                cmd = CMD_INSTR;
            else if (k < 90)
                cmd = CMD_CURSOR;
            else
                cmd = CMD_INIT;
            val = 8'($urandom_range(0, 255));
            // Steer some bytes onto clear and home to hit the long wait.
            if (cmd != CMD_CURSOR && cmd != CMD_INIT && $urandom_range(0, 3) == 0)
                val = $urandom_range(0, 1) ? INSTR_CLEAR : INSTR_HOME;
            send_request(cmd, val, 6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
        end
        end_requests();
    endtask

    initial
    begin
        sb        = new();
        rst_n     = 1'b0;
        start     = 1'b0;
        command   = CMD_DATA;
        value     = '0;
        col       = '0;
        row       = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_SETTLE;
        cfg_data  = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset timing values, every request kind and the field extremes.
        send_request(CMD_DATA, 8'h00, 6'd0, 1'b0);
        send_request(CMD_DATA, 8'hFF, 6'd63, 1'b1);
        send_request(CMD_DATA, INSTR_CLEAR, 6'd5, 1'b0);
        send_request(CMD_DATA, INSTR_HOME, 6'd9, 1'b1);
        send_request(CMD_INSTR, 8'h00, 6'd0, 1'b0);
        send_request(CMD_INSTR, 8'hFF, 6'd63, 1'b1);
        send_request(CMD_INSTR, INSTR_CLEAR, 6'd0, 1'b0);
        send_request(CMD_INSTR, INSTR_HOME, 6'd0, 1'b0);
        send_request(CMD_INSTR, 8'h03, 6'd0, 1'b0);
        send_request(CMD_CURSOR, 8'hFF, 6'd0, 1'b0);
        send_request(CMD_CURSOR, 8'h00, 6'd63, 1'b0);
        send_request(CMD_CURSOR, 8'h01, 6'd0, 1'b1);
        send_request(CMD_CURSOR, 8'h02, 6'd63, 1'b1);
        send_request(CMD_CURSOR, 8'hA5, 6'd37, 1'b1);
        send_request(CMD_INIT, 8'h5A, 6'd21, 1'b1);
        end_requests();

        // All waits zero.
        program_timing('0, '0, '0, '0, '0, 1'b0);
        send_request(CMD_INIT, 8'hFF, 6'd63, 1'b0);
        send_request(CMD_INSTR, INSTR_CLEAR, 6'd0, 1'b0);
        send_request(CMD_DATA, 8'hA5, 6'd0, 1'b0);
        send_request(CMD_CURSOR, 8'h00, 6'd12, 1'b1);
        end_requests();

        // All waits at their maximum, so the sums need all 17 bits of the wait field.
        program_timing('1, '1, '1, '1, '1, 1'b1);
        send_request(CMD_INIT, 8'h00, 6'd0, 1'b1);
        send_request(CMD_INSTR, INSTR_HOME, 6'd0, 1'b0);
        send_request(CMD_CURSOR, 8'h00, 6'd63, 1'b1);
        send_request(CMD_DATA, INSTR_HOME, 6'd0, 1'b0);
        end_requests();

        program_random(65535);
        run_random_phase(115, 60);
        program_random(65535);
        run_random_phase(115, 0);
        program_random(255);
        run_random_phase(115, 0);
        program_random(65535);
        run_random_phase(115, 0);

        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/clns_pkg.sv
hw/rtl/clns_ctrl.sv
hw/rtl/clns_datapath.sv
hw/rtl/char_lcd_nibble_sequencer.sv
test/tb_char_lcd_nibble_sequencer.sv
